### design/rscp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rscp_pkg - shared definitions for the ring slice cubic player
// Widths, operation codes, register indexes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package rscp_pkg;

	// ring and number formats
	localparam int RING_DEPTH  = 32768;
	localparam int RING_AW     = $clog2(RING_DEPTH);
	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 16;
	localparam int POS_BITS    = RING_AW + FRAC_BITS;
	localparam int LEN_BITS    = 16;
	localparam int LENQ_BITS   = LEN_BITS + FRAC_BITS;
	localparam int HEAD_BITS   = 32;
	localparam int SPEED_BITS  = 24;
	localparam int MIN_STEP    = (1 << FRAC_BITS) / 100;
	localparam int ACC_BITS    = 24;
	localparam int PROD_BITS   = ACC_BITS + FRAC_BITS + 1;
	localparam int WRAP_BITS   = 18;

	// shared divider widths
	localparam int DVD_BITS = 34;
	localparam int DVS_BITS = 32;
	localparam int DCNT_BITS = $clog2(DVD_BITS + 1);

	// operation codes carried in tuser
	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_TICK    = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	// register indexes
	localparam logic [2:0] REG_VOICE_ENABLE  = 3'd0;
	localparam logic [2:0] REG_REVERSE_MODE  = 3'd1;
	localparam logic [2:0] REG_CHOPPY_MODE   = 3'd2;
	localparam logic [2:0] REG_SLICE_LENGTH  = 3'd3;
	localparam logic [2:0] REG_PHRASE_START  = 3'd4;
	localparam logic [2:0] REG_PHRASE_LENGTH = 3'd5;
	localparam logic [2:0] REG_PLAY_SPEED    = 3'd6;
	localparam logic [2:0] REG_INIT_SLICE    = 3'd7;

	typedef struct packed {
		logic                  voice_enable;
		logic                  reverse_mode;
		logic                  choppy_mode;
		logic [LEN_BITS-1:0]   slice_length;
		logic [RING_AW-1:0]    phrase_start;
		logic [LEN_BITS-1:0]   phrase_length;
		logic [SPEED_BITS-1:0] play_speed;
		logic [RING_AW-1:0]    initial_slice_start;
	} cfg_t;

	// what the shared divider is working on
	typedef enum logic [1:0] {
		DS_PHASE = 2'd0,
		DS_ADV   = 2'd1,
		DS_REL   = 2'd2,
		DS_NXT   = 2'd3
	} div_sel_t;

	typedef struct packed {
		logic       clr;
		logic       latch;
		logic       do_write;
		logic       do_restart;
		logic       div_start;
		div_sel_t   div_sel;
		logic       tap_rd;
		logic [1:0] tap_idx;
		logic       coef;
		logic       mul;
		logic       add;
		logic [1:0] hstep;
		logic       rnd;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic       clr_done;
		logic [1:0] op;
		logic       run;
		logic       div_done;
		logic       wraps_zero;
		logic       choppy;
		logic       out_free;
	} sts_t;

endpackage
`default_nettype wire

### design/rscp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rscp_div - shared restoring divider
// One quotient bit per cycle; gives quotient and remainder, done pulses once.
// ----------------------------------------------------------------------------
module rscp_div import rscp_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [DVD_BITS-1:0] dvd,
	input  wire logic [DVS_BITS-1:0] dvs,
	output logic                     done,
	output logic [DVD_BITS-1:0]      quo,
	output logic [DVS_BITS-1:0]      rem
);

	logic                 busy_q;
	logic                 done_q;
	logic [DCNT_BITS-1:0] cnt_q;
	logic [DVD_BITS-1:0]  quo_q;
	logic [DVS_BITS-1:0]  rem_q;
	logic [DVS_BITS-1:0]  dvs_q;
	logic [DVS_BITS:0]    trial;
	logic [DVS_BITS:0]    diff;
	logic                 ge;

	// trial subtraction for the next bit
	always_comb begin
		trial = {rem_q, quo_q[DVD_BITS-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_BITS'(DVD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dvd;
			rem_q <= '0;
			dvs_q <= dvs;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_BITS-2:0], ge};
			rem_q <= ge ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

### design/rscp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rscp_datapath - sample ring, playhead state and cubic interpolator
// Holds the ring memory with its clearing counter, the playhead and slice
// start, the tap registers, the Horner accumulator and the output register.
// ----------------------------------------------------------------------------
module rscp_datapath import rscp_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cfg_t                          cfg,
	input  wire cmd_t                          cmd,
	output sts_t                               sts,
	input  wire logic [1:0]                    in_op,
	input  wire logic [RING_AW-1:0]            in_addr,
	input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic signed [SAMPLE_BITS-1:0]      out_sample,
	output logic                               out_audio
);

	localparam logic signed [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// ring memory
	logic signed [SAMPLE_BITS-1:0] ring [RING_DEPTH];
	logic signed [SAMPLE_BITS-1:0] mem_q;
	logic [RING_AW-1:0]            clr_cnt_q;
	logic                          mem_we;
	logic [RING_AW-1:0]            mem_wa;
	logic signed [SAMPLE_BITS-1:0] mem_wd;
	logic [RING_AW-1:0]            mem_ra;

	// item and voice state
	logic [1:0]                    op_q;
	logic [RING_AW-1:0]            waddr_q;
	logic signed [SAMPLE_BITS-1:0] wsample_q;
	logic [HEAD_BITS-1:0]          playhead_q;
	logic [RING_AW-1:0]            slice_q;
	logic [WRAP_BITS-1:0]          wraps_q;
	logic [LEN_BITS-1:0]           rel_q;
	logic                          rel_neg_q;
	div_sel_t                      sel_q;
	logic [POS_BITS-1:0]           pos_q;

	// interpolator
	logic signed [SAMPLE_BITS-1:0] y_q [4];
	logic                          tap_pend_s1;
	logic [1:0]                    tap_idx_s1;
	logic signed [ACC_BITS-1:0]    r_q, c2_q, c1_q, c0_q;
	logic signed [PROD_BITS-1:0]   prod_s1;
	logic signed [SAMPLE_BITS-1:0] sample_q;

	// output register
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;
	logic                          out_audio_q;

	// divider connection
	logic [DVD_BITS-1:0] dvd;
	logic [DVS_BITS-1:0] dvs;
	logic                div_done;
	logic [DVD_BITS-1:0] div_quo;
	logic [DVS_BITS-1:0] div_rem;

	// combinational helpers
	logic [SPEED_BITS-1:0]      step;
	logic [LENQ_BITS-1:0]       len_q;
	logic [LEN_BITS-1:0]        rel_diff;
	logic [LEN_BITS-1:0]        rel_mag;
	logic [LEN_BITS-1:0]        rel_fix;
	logic [POS_BITS-1:0]        phase;
	logic [POS_BITS+1:0]        pos_off;
	logic [POS_BITS+1:0]        pos_sum;
	logic signed [ACC_BITS-1:0] e0, e1, e2, e3, c3, c2, c1, c0;
	logic signed [PROD_BITS-1:0] rnd_prod;
	logic signed [ACC_BITS-1:0] csel;
	logic signed [ACC_BITS-1:0] half_r;
	logic signed [SAMPLE_BITS-1:0] sat_r;

	rscp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.dvd    (dvd),
		.dvs    (dvs),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// speed floor, slice length in phase units, phrase offset
	always_comb begin
		step     = (cfg.play_speed > SPEED_BITS'(MIN_STEP)) ? cfg.play_speed
		                                                    : SPEED_BITS'(MIN_STEP);
		len_q    = {cfg.slice_length, {FRAC_BITS{1'b0}}};
		rel_diff = {1'b0, slice_q} - {1'b0, cfg.phrase_start};
		rel_mag  = rel_diff[LEN_BITS-1] ? (LEN_BITS'(0) - rel_diff) : rel_diff;
	end

	// divider operand selection
	always_comb begin
		dvd = '0;
		dvs = DVS_BITS'(len_q);
		case (cmd.div_sel)
			DS_PHASE: begin
				dvd = DVD_BITS'(playhead_q);
			end
			DS_ADV: begin
				dvd = DVD_BITS'(playhead_q) + DVD_BITS'(step);
			end
			DS_REL: begin
				dvd = DVD_BITS'(rel_mag);
				dvs = DVS_BITS'(cfg.phrase_length);
			end
			default: begin
				dvd = DVD_BITS'(rel_q) + DVD_BITS'(cfg.slice_length);
				dvs = DVS_BITS'(cfg.phrase_length);
			end
		endcase
	end

	// read position from the phase, forwards or from the slice end
	always_comb begin
		phase = div_rem[POS_BITS-1:0];
		if (cfg.reverse_mode)
			pos_off = (POS_BITS+2)'(len_q) - (POS_BITS+2)'(1 << FRAC_BITS)
			          - (POS_BITS+2)'(phase);
		else
			pos_off = (POS_BITS+2)'(phase);
		pos_sum = (POS_BITS+2)'({slice_q, {FRAC_BITS{1'b0}}}) + pos_off;
	end

	// offset into the phrase, wrapped for a negative difference
	always_comb begin
		if (cfg.phrase_length == '0)
			rel_fix = '0;
		else if (rel_neg_q && div_rem[LEN_BITS-1:0] != '0)
			rel_fix = cfg.phrase_length - div_rem[LEN_BITS-1:0];
		else
			rel_fix = div_rem[LEN_BITS-1:0];
	end

	// voice state and divider result capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q       <= OP_WRITE;
			playhead_q <= '0;
			slice_q    <= '0;
			wraps_q    <= '0;
			sel_q      <= DS_PHASE;
			rel_neg_q  <= 1'b0;
			rel_q      <= '0;
			pos_q      <= '0;
		end else begin
			if (cmd.latch)
				op_q <= in_op;
			if (cmd.do_restart) begin
				playhead_q <= '0;
				slice_q    <= cfg.initial_slice_start;
			end
			if (cmd.div_start) begin
				sel_q     <= cmd.div_sel;
				rel_neg_q <= rel_diff[LEN_BITS-1];
			end
			if (div_done) begin
				case (sel_q)
					DS_PHASE: pos_q <= pos_sum[POS_BITS-1:0];
					DS_ADV: begin
						playhead_q <= div_rem[HEAD_BITS-1:0];
						wraps_q    <= div_quo[WRAP_BITS-1:0];
					end
					DS_REL: rel_q <= rel_fix;
					default: begin
						slice_q <= cfg.phrase_start
						           + ((cfg.phrase_length == '0) ? RING_AW'(0)
						                                        : div_rem[RING_AW-1:0]);
						wraps_q <= wraps_q - 1'b1;
					end
				endcase
			end
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			waddr_q   <= in_addr;
			wsample_q <= in_sample;
		end
	end

	// clearing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_cnt_q <= '0;
		else if (cmd.clr)
			clr_cnt_q <= clr_cnt_q + 1'b1;
	end

	// ring port selection
	always_comb begin
		mem_we = cmd.clr || cmd.do_write;
		mem_wa = cmd.clr ? clr_cnt_q : waddr_q;
		mem_wd = cmd.clr ? SAMPLE_BITS'(0) : wsample_q;
		mem_ra = pos_q[POS_BITS-1:FRAC_BITS] + RING_AW'(cmd.tap_idx) - RING_AW'(1);
	end

	// ring memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			ring[mem_wa] <= mem_wd;
		mem_q <= ring[mem_ra];
	end

	// tap capture in the cycle after the registered read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_pend_s1 <= 1'b0;
			tap_idx_s1  <= '0;
		end else begin
			tap_pend_s1 <= cmd.tap_rd;
			tap_idx_s1  <= cmd.tap_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (tap_pend_s1)
			y_q[tap_idx_s1] <= mem_q;
	end

	// doubled Catmull-Rom coefficients
	always_comb begin
		e0 = ACC_BITS'(y_q[0]);
		e1 = ACC_BITS'(y_q[1]);
		e2 = ACC_BITS'(y_q[2]);
		e3 = ACC_BITS'(y_q[3]);
		c3 = e3 - e0 + ((e1 - e2) <<< 1) + (e1 - e2);
		c2 = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
		c1 = e2 - e0;
		c0 = e1 <<< 1;
	end

	// Horner step operands and final rounding
	always_comb begin
		rnd_prod = (prod_s1 + PROD_BITS'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
		case (cmd.hstep)
			2'd0:    csel = c2_q;
			2'd1:    csel = c1_q;
			default: csel = c0_q;
		endcase
		half_r = (r_q + ACC_BITS'(1)) >>> 1;
		if (half_r > ACC_BITS'(SAT_HI))
			sat_r = SAT_HI;
		else if (half_r < ACC_BITS'(SAT_LO))
			sat_r = SAT_LO;
		else
			sat_r = half_r[SAMPLE_BITS-1:0];
	end

	// interpolator registers
	always_ff @(posedge clk) begin
		if (cmd.latch)
			sample_q <= '0;
		if (cmd.coef) begin
			r_q  <= c3;
			c2_q <= c2;
			c1_q <= c1;
			c0_q <= c0;
		end
		if (cmd.mul)
			prod_s1 <= r_q * $signed({1'b0, pos_q[FRAC_BITS-1:0]});
		if (cmd.add)
			r_q <= $signed(rnd_prod[ACC_BITS-1:0]) + csel;
		if (cmd.rnd)
			sample_q <= sat_r;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_sample_q <= sample_q;
			out_audio_q  <= (op_q == OP_TICK);
		end
	end

	// status to the controller
	always_comb begin
		sts.clr_done   = &clr_cnt_q;
		sts.op         = op_q;
		sts.run        = cfg.voice_enable && (cfg.slice_length != '0);
		sts.div_done   = div_done;
		sts.wraps_zero = (wraps_q == '0);
		sts.choppy     = cfg.choppy_mode;
		sts.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign out_audio  = out_audio_q;

endmodule
`default_nettype wire

### design/rscp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rscp_ctrl - sequencer for the ring slice cubic player
// Clears the ring after reset, then runs one item at a time through
// dispatch, phase division, tap reads, Horner steps and the slice advance.
// ----------------------------------------------------------------------------
module rscp_ctrl import rscp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [14:0] {
		S_CLR   = 15'b000000000000001,
		S_IDLE  = 15'b000000000000010,
		S_DISP  = 15'b000000000000100,
		S_PHASE = 15'b000000000001000,
		S_TAP   = 15'b000000000010000,
		S_COEF  = 15'b000000000100000,
		S_MUL   = 15'b000000001000000,
		S_ADD   = 15'b000000010000000,
		S_RND   = 15'b000000100000000,
		S_ADV   = 15'b000001000000000,
		S_WCHK  = 15'b000010000000000,
		S_REL   = 15'b000100000000000,
		S_NXTS  = 15'b001000000000000,
		S_NXT   = 15'b010000000000000,
		S_FIN   = 15'b100000000000000
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] tap_cnt_q, tap_cnt_d;
	logic [1:0] h_cnt_q, h_cnt_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d   = state_q;
		tap_cnt_d = tap_cnt_q;
		h_cnt_d   = h_cnt_q;
		cmd       = '0;
		cmd.hstep = h_cnt_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_FIN;
				case (sts.op)
					OP_WRITE:   cmd.do_write = 1'b1;
					OP_RESTART: cmd.do_restart = 1'b1;
					OP_TICK: begin
						if (sts.run) begin
							cmd.div_start = 1'b1;
							cmd.div_sel   = DS_PHASE;
							state_d       = S_PHASE;
						end
					end
					default: ;
				endcase
			end
			S_PHASE: begin
				if (sts.div_done) begin
					tap_cnt_d = '0;
					state_d   = S_TAP;
				end
			end
			S_TAP: begin
				tap_cnt_d = tap_cnt_q + 1'b1;
				if (tap_cnt_q[2]) begin
					tap_cnt_d = '0;
					state_d   = S_COEF;
				end else begin
					cmd.tap_rd  = 1'b1;
					cmd.tap_idx = tap_cnt_q[1:0];
				end
			end
			S_COEF: begin
				cmd.coef = 1'b1;
				h_cnt_d  = '0;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.add = 1'b1;
				if (h_cnt_q == 2'd2) begin
					h_cnt_d = '0;
					state_d = S_RND;
				end else begin
					h_cnt_d = h_cnt_q + 1'b1;
					state_d = S_MUL;
				end
			end
			S_RND: begin
				cmd.rnd       = 1'b1;
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_ADV;
				state_d       = S_ADV;
			end
			S_ADV: begin
				cmd.div_sel = DS_ADV;
				if (sts.div_done)
					state_d = S_WCHK;
			end
			S_WCHK: begin
				if (sts.choppy || sts.wraps_zero) begin
					state_d = S_FIN;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DS_REL;
					state_d       = S_REL;
				end
			end
			S_REL: begin
				cmd.div_sel = DS_REL;
				if (sts.div_done)
					state_d = S_NXTS;
			end
			S_NXTS: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_NXT;
				state_d       = S_NXT;
			end
			S_NXT: begin
				cmd.div_sel = DS_NXT;
				if (sts.div_done)
					state_d = S_WCHK;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			tap_cnt_q <= '0;
			h_cnt_q   <= '0;
		end else begin
			state_q   <= state_d;
			tap_cnt_q <= tap_cnt_d;
			h_cnt_q   <= h_cnt_d;
		end
	end

`ifndef SYNTHESIS
	// a result is only loaded when the output register can take it
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result loaded over a waiting result");

	// an accepted item always goes to dispatch
	a_latch_disp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch |=> (state_q == S_DISP))
		else $error("accepted item not dispatched");

	// the divider never finishes right after a start
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !sts.div_done)
		else $error("divider finished too early");

	// no ring write from an item during the clearing pass
	a_clr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |-> !(cmd.do_write || cmd.latch))
		else $error("item activity during ring clear");
`endif

endmodule
`default_nettype wire

### design/ring_slice_cubic_player_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ring_slice_cubic_player_core - looping slice player with cubic interpolation
// Ring writes, ticks that render one Catmull-Rom sample and advance the
// playhead, and restarts; configuration over an APB register port.
// ----------------------------------------------------------------------------
//  channel | direction | transaction
//  s_*     | in        | one item: tuser = operation, tdata = address, sample
//  m_*     | out       | one result per item: tdata = sample, tuser = is_audio
//  apb     | in/out    | register write or read, no wait states
//
//  After reset a clearing pass zeroes the ring; no items are taken during it.
//  Write, restart and silent ticks go from dispatch straight to the output stage.
//  A sounding tick renders its sample and advances the playhead on the shared
//  bit-serial divider, with two more divisions per slice wrap unless choppy.
//  A new item is taken while the previous result waits in the output register.
// ----------------------------------------------------------------------------
module ring_slice_cubic_player_core import rscp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [14:0] write_address, [30:15] write_sample
	input  wire logic [1:0]  s_tuser,   // [1:0] operation
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [15:0] audio_sample
	output logic [0:0]       m_tuser,   // [0] is_audio
	// register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam cfg_t CFG_RESET = '{play_speed: SPEED_BITS'(1 << FRAC_BITS), default: '0};

	cfg_t                          cfg_q;
	cmd_t                          cmd;
	sts_t                          sts;
	logic [2:0]                    reg_idx;
	logic                          reg_wr;
	logic signed [SAMPLE_BITS-1:0] out_sample;
	logic                          out_audio;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign reg_wr  = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_VOICE_ENABLE:  cfg_q.voice_enable        <= pwdata[0];
				REG_REVERSE_MODE:  cfg_q.reverse_mode        <= pwdata[0];
				REG_CHOPPY_MODE:   cfg_q.choppy_mode         <= pwdata[0];
				REG_SLICE_LENGTH:  cfg_q.slice_length        <= pwdata[LEN_BITS-1:0];
				REG_PHRASE_START:  cfg_q.phrase_start        <= pwdata[RING_AW-1:0];
				REG_PHRASE_LENGTH: cfg_q.phrase_length       <= pwdata[LEN_BITS-1:0];
				REG_PLAY_SPEED:    cfg_q.play_speed          <= pwdata[SPEED_BITS-1:0];
				REG_INIT_SLICE:    cfg_q.initial_slice_start <= pwdata[RING_AW-1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (reg_idx)
			REG_VOICE_ENABLE:  prdata = 32'(cfg_q.voice_enable);
			REG_REVERSE_MODE:  prdata = 32'(cfg_q.reverse_mode);
			REG_CHOPPY_MODE:   prdata = 32'(cfg_q.choppy_mode);
			REG_SLICE_LENGTH:  prdata = 32'(cfg_q.slice_length);
			REG_PHRASE_START:  prdata = 32'(cfg_q.phrase_start);
			REG_PHRASE_LENGTH: prdata = 32'(cfg_q.phrase_length);
			REG_PLAY_SPEED:    prdata = 32'(cfg_q.play_speed);
			REG_INIT_SLICE:    prdata = 32'(cfg_q.initial_slice_start);
			default:           prdata = '0;
		endcase
	end

	rscp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rscp_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd        (cmd),
		.sts        (sts),
		.in_op      (s_tuser),
		.in_addr    (s_tdata[RING_AW-1:0]),
		.in_sample  ($signed(s_tdata[RING_AW+SAMPLE_BITS-1:RING_AW])),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_sample (out_sample),
		.out_audio  (out_audio)
	);

	assign m_tdata    = out_sample;
	assign m_tuser[0] = out_audio;

endmodule
`default_nettype wire
